/* src/tss_pkg.sv */
// Shared types, codes and sizing for the tagged stack with search.
// Used by tss_store, tagged_stack_with_search and the bench; no dependencies.
`default_nettype none

package tss_pkg;

	localparam int DEPTH = 64;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		OP_PUSH        = 3'd0,
		OP_PUSH_UNIQUE = 3'd1,
		OP_POP         = 3'd2,
		OP_TOP         = 3'd3,
		OP_TOP_OF_TYPE = 3'd4,
		OP_CONTAINS    = 3'd5,
		OP_CLEAR       = 3'd6,
		OP_NONE        = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [63:0] value;
		logic [7:0]  tag;
	} entry_t;

	typedef struct packed {
		logic          en;
		logic [AW-1:0] addr;
		entry_t        data;
	} wr_t;

endpackage

`default_nettype wire

/* src/tss_store.sv */
// Entry store: DEPTH value/type pairs, one write and one registered read a cycle.
// Depends on tss_pkg.
`default_nettype none

module tss_store
	import tss_pkg::*;
(
	input  wire logic          clk,
	input  wire wr_t           wr,
	input  wire logic [AW-1:0] rd_addr,
	output entry_t             rd_data
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

/* src/tagged_stack_with_search.sv */
// Tagged LIFO stack with associative search: top level, sequencer and output register.
// Depends on tss_pkg and tss_store.
//
// Usage:
//   s_* carries one command beat (op, item_value, item_type); m_* returns one
//   result beat per command (read_value, hit, status, depth_used).
//   s_tready is high only while the sequencer is idle; one command at a time.
//   Push and clear go from accept through S_EXEC and S_DONE to the output
//   register; pop and top on a non-empty stack also pass through S_SCAN.
//   Top-of-type walks down from the top and contains / push-unique walk up
//   from the bottom, one stored entry per cycle through the single read port
//   of the store and one shared compare, visiting at most DEPTH entries. A new
//   command can be accepted the cycle after the result is loaded into the output register.
//   If the receiver stalls, the result holds in m_tdata and the next command
//   may be accepted and worked on; it parks finished until the output frees.
//   Reset empties the stack (fill count to zero) and drops any pending
//   result; entry contents are left as they are and never used above depth.
`default_nettype none

module tagged_stack_with_search
	import tss_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,  // op[2:0], item_value[66:3], item_type[74:67]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata   // read_value[63:0], hit[64], status[66:65],
	                                   // depth_used[73:67]
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_DONE
	} state_t;

	state_t        state_q;
	op_t           op_q;
	logic [63:0]   val_q;
	logic [7:0]    typ_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] idx_q;
	logic [63:0]   res_rv_q;
	logic          res_hit_q;
	status_t       res_st_q;
	logic          m_tvalid_q;
	logic [79:0]   m_tdata_q;

	wr_t           wr;
	logic [AW-1:0] rd_addr;
	entry_t        rd_data;

	logic          full;
	logic          empty;
	logic [AW-1:0] top_idx;
	logic          up;
	logic          last;
	logic          match;
	logic          load_out;

	tss_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign top_idx  = AW'(count_q - CW'(1));
	assign up       = (op_q == OP_PUSH_UNIQUE) || (op_q == OP_CONTAINS);
	assign last     = up ? (idx_q == top_idx) : (idx_q == '0);
	assign load_out = (state_q == S_DONE) && (!m_tvalid_q || m_tready);

	// shared compare against the entry read last cycle
	always_comb begin
		case (op_q)
			OP_POP, OP_TOP: match = 1'b1;
			OP_TOP_OF_TYPE: match = (rd_data.tag == typ_q);
			default:        match = (rd_data.tag == typ_q) && (rd_data.value == val_q);
		endcase
	end

	always_comb begin
		rd_addr       = idx_q;
		wr.en         = 1'b0;
		wr.addr       = count_q[AW-1:0];
		wr.data.value = val_q;
		wr.data.tag   = typ_q;
		case (state_q)
			S_EXEC: begin
				rd_addr = up ? '0 : top_idx;
				if (op_q == OP_PUSH && !full) begin
					wr.en = 1'b1;
				end
				if (op_q == OP_PUSH_UNIQUE && empty) begin
					wr.en = 1'b1;
				end
			end
			S_SCAN: begin
				rd_addr = up ? idx_q + AW'(1) : idx_q - AW'(1);
				if (op_q == OP_PUSH_UNIQUE && !match && last && !full) begin
					wr.en = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q    <= op_t'(s_tdata[2:0]);
						val_q   <= s_tdata[66:3];
						typ_q   <= s_tdata[74:67];
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_rv_q  <= '0;
					res_hit_q <= 1'b0;
					res_st_q  <= ST_OK;
					state_q   <= S_DONE;
					case (op_q)
						OP_PUSH: begin
							if (full) begin
								res_st_q <= ST_FULL;
							end else begin
								count_q <= count_q + CW'(1);
							end
						end
						OP_PUSH_UNIQUE, OP_CONTAINS: begin
							if (!empty) begin
								idx_q   <= '0;
								state_q <= S_SCAN;
							end else if (op_q == OP_PUSH_UNIQUE) begin
								count_q <= count_q + CW'(1);
							end
						end
						OP_POP, OP_TOP, OP_TOP_OF_TYPE: begin
							if (empty) begin
								res_st_q <= ST_EMPTY;
							end else begin
								idx_q   <= top_idx;
								state_q <= S_SCAN;
							end
						end
						OP_CLEAR: begin
							count_q <= '0;
						end
						default: begin
						end
					endcase
				end
				S_SCAN: begin
					if (match) begin
						state_q <= S_DONE;
						case (op_q)
							OP_POP: begin
								res_rv_q <= rd_data.value;
								count_q  <= count_q - CW'(1);
							end
							OP_TOP, OP_TOP_OF_TYPE: begin
								res_rv_q <= rd_data.value;
							end
							default: begin
								res_hit_q <= 1'b1;
							end
						endcase
					end else if (last) begin
						state_q <= S_DONE;
						case (op_q)
							OP_TOP_OF_TYPE: begin
								res_st_q <= ST_EMPTY;
							end
							OP_PUSH_UNIQUE: begin
								if (full) begin
									res_st_q <= ST_FULL;
								end else begin
									count_q <= count_q + CW'(1);
								end
							end
							default: begin
							end
						endcase
					end else begin
						idx_q <= up ? idx_q + AW'(1) : idx_q - AW'(1);
					end
				end
				S_DONE: begin
					if (load_out) begin
						m_tdata_q <= {6'd0, 7'(count_q), res_st_q, res_hit_q, res_rv_q};
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count above DEPTH");

	a_count_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE) |=> $stable(count_q))
		else $error("fill count moved outside exec/scan");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (count_q < CW'(DEPTH)))
		else $error("store write on a full stack");

	a_full_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[66:65] == ST_FULL) |-> (m_tdata[73:67] == 7'(DEPTH)))
		else $error("full status with depth below DEPTH");

	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[64]) |-> (m_tdata[66:65] == ST_OK))
		else $error("hit reported with non-ok status");

endmodule

`default_nettype wire

/* tb/tagged_stack_with_search_test.sv */
// Self-checking bench for the tagged LIFO stack with associative search.
// Needs tss_pkg and tagged_stack_with_search; directed table first, then random
// phases (fill, mixed, drain); beats are checked against typed rows or a behavioral stack.
module tagged_stack_with_search_test
	import tss_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	typedef enum {PH_FILL, PH_MIX, PH_DRAIN} phase_t;

	typedef struct packed {
		op_t         op;
		logic [63:0] value;
		logic [7:0]  tag;
	} cmd_t;

	typedef struct packed {
		logic [63:0] read_value;
		logic        hit;
		logic [1:0]  status;
		logic [6:0]  depth;
	} result_t;

	typedef struct packed {
		op_t         op;
		logic [63:0] value;
		logic [7:0]  tag;
		logic        known;
		result_t     res;
	} dir_row_t;

	localparam logic [63:0] ALL_ONES = '1;
	localparam int RANDOM_ITEMS = 800;
	localparam int LONG_HOLD    = 400;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;  // op[2:0], item_value[66:3], item_type[74:67]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;       // read_value[63:0], hit[64], status[66:65],
	                            // depth_used[73:67]

	// behavioral copy of the stack
	logic [63:0] stack_values [DEPTH];
	logic [7:0]  stack_tags [DEPTH];
	int          stack_fill = 0;

	result_t results_due[$];
	int      errors = 0;
	int      cmds_accepted = 0;
	int      burst_left = 0;

	logic [63:0] value_pool [8];
	logic [7:0]  tag_pool [4];

	// known rows carry typed results; the rest go through the predictor
	dir_row_t directed_rows [25] = '{
		'{OP_POP,         64'h0,      8'h00, 1'b1, '{64'h0, 1'b0, ST_EMPTY, 7'd0}},
		'{OP_TOP,         64'h0,      8'h00, 1'b1, '{64'h0, 1'b0, ST_EMPTY, 7'd0}},
		'{OP_TOP_OF_TYPE, 64'h0,      8'hFF, 1'b1, '{64'h0, 1'b0, ST_EMPTY, 7'd0}},
		'{OP_CONTAINS,    ALL_ONES,   8'hFF, 1'b1, '{64'h0, 1'b0, ST_OK, 7'd0}},
		'{OP_NONE,        ALL_ONES,   8'hFF, 1'b1, '{64'h0, 1'b0, ST_OK, 7'd0}},
		'{OP_PUSH,        ALL_ONES,   8'hFF, 1'b1, '{64'h0, 1'b0, ST_OK, 7'd1}},
		'{OP_PUSH,        64'h0,      8'h00, 1'b1, '{64'h0, 1'b0, ST_OK, 7'd2}},
		'{OP_PUSH_UNIQUE, ALL_ONES,   8'hFF, 1'b1, '{64'h0, 1'b1, ST_OK, 7'd2}},
		'{OP_PUSH_UNIQUE, 64'h1,      8'h80, 1'b1, '{64'h0, 1'b0, ST_OK, 7'd3}},
		'{OP_CONTAINS,    ALL_ONES,   8'hFF, 1'b1, '{64'h0, 1'b1, ST_OK, 7'd3}},
		'{OP_CONTAINS,    ALL_ONES,   8'h00, 1'b1, '{64'h0, 1'b0, ST_OK, 7'd3}},
		'{OP_TOP,         64'h0,      8'h00, 1'b1, '{64'h1, 1'b0, ST_OK, 7'd3}},
		'{OP_TOP_OF_TYPE, 64'h0,      8'hFF, 1'b1, '{ALL_ONES, 1'b0, ST_OK, 7'd3}},
		'{OP_TOP_OF_TYPE, 64'h0,      8'h55, 1'b1, '{64'h0, 1'b0, ST_EMPTY, 7'd3}},
		'{OP_TOP_OF_TYPE, ALL_ONES,   8'h00, 1'b1, '{64'h0, 1'b0, ST_OK, 7'd3}},
		'{OP_NONE,        64'h0,      8'h00, 1'b1, '{64'h0, 1'b0, ST_OK, 7'd3}},
		'{OP_POP,         64'h0,      8'h00, 1'b1, '{64'h1, 1'b0, ST_OK, 7'd2}},
		'{OP_PUSH,        64'h8000_0000_0000_0000, 8'h01, 1'b0, '0},
		'{OP_PUSH_UNIQUE, 64'h5555_5555_5555_5555, 8'hAA, 1'b0, '0},
		'{OP_TOP_OF_TYPE, 64'h0,      8'hFF, 1'b0, '0},
		'{OP_POP,         64'h0,      8'h00, 1'b0, '0},
		'{OP_CLEAR,       ALL_ONES,   8'hFF, 1'b1, '{64'h0, 1'b0, ST_OK, 7'd0}},
		'{OP_POP,         64'h0,      8'h00, 1'b1, '{64'h0, 1'b0, ST_EMPTY, 7'd0}},
		'{OP_PUSH_UNIQUE, 64'hAAAA_AAAA_AAAA_AAAA, 8'h55, 1'b0, '0},
		'{OP_CONTAINS,    64'hAAAA_AAAA_AAAA_AAAA, 8'h55, 1'b0, '0}
	};

	tagged_stack_with_search uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic bit pair_stored(logic [63:0] value, logic [7:0] tag);
		for (int i = 0; i < stack_fill; i++)
			if (stack_values[i] == value && stack_tags[i] == tag)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic [1:0] push_entry(logic [63:0] value, logic [7:0] tag);
		if (stack_fill >= DEPTH)
			return ST_FULL;
		stack_values[stack_fill] = value;
		stack_tags[stack_fill]   = tag;
		stack_fill++;
		return ST_OK;
	endfunction

	function automatic result_t apply_stack_op(cmd_t c);
		result_t r;
		bit      found;
		r = '0;
		found = 1'b0;
		case (c.op)
			OP_PUSH: r.status = push_entry(c.value, c.tag);
			OP_PUSH_UNIQUE: begin
				if (pair_stored(c.value, c.tag))
					r.hit = 1'b1;
				else
					r.status = push_entry(c.value, c.tag);
			end
			OP_POP: begin
				if (stack_fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					stack_fill--;
					r.read_value = stack_values[stack_fill];
				end
			end
			OP_TOP: begin
				if (stack_fill == 0)
					r.status = ST_EMPTY;
				else
					r.read_value = stack_values[stack_fill - 1];
			end
			OP_TOP_OF_TYPE: begin
				r.status = ST_EMPTY;
				for (int i = stack_fill - 1; i >= 0; i--) begin
					if (!found && stack_tags[i] == c.tag) begin
						found = 1'b1;
						r.read_value = stack_values[i];
						r.status = ST_OK;
					end
				end
			end
			OP_CONTAINS: r.hit = pair_stored(c.value, c.tag);
			OP_CLEAR: stack_fill = 0;
			default: ;
		endcase
		r.depth = 7'(stack_fill);
		return r;
	endfunction

	task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
		$display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
		errors++;
	endtask

	task automatic check_beat(input logic [79:0] beat);
		result_t want;
		if (results_due.size() == 0) begin
			report("result beat with nothing outstanding", 64'h0, beat[63:0]);
			return;
		end
		want = results_due.pop_front();
		if (beat[63:0] !== want.read_value)
			report("read_value", want.read_value, beat[63:0]);
		if (beat[64] !== want.hit)
			report("hit", 64'(want.hit), 64'(beat[64]));
		if (beat[66:65] !== want.status)
			report("status", 64'(want.status), 64'(beat[66:65]));
		if (beat[73:67] !== want.depth)
			report("depth_used", 64'(want.depth), 64'(beat[73:67]));
	endtask

	// sender: bursts of back-to-back beats with random gaps between them
	task automatic send_cmd(input cmd_t c, input bit known, input result_t typed);
		result_t due;
		int      gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, c.tag, c.value, c.op};
		do @(posedge clk); while (!s_tready);
		burst_left--;
		due = apply_stack_op(c);
		if (known)
			due = typed;
		results_due.push_back(due);
		cmds_accepted++;
	endtask

	function automatic logic [63:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return value_pool[$urandom_range(0, 7)];
		if (r == 4)
			return $urandom_range(0, 1) ? ALL_ONES : 64'h0;
		return {$urandom, $urandom};
	endfunction

	function automatic logic [7:0] pick_tag();
		if ($urandom_range(0, 9) < 6)
			return tag_pool[$urandom_range(0, 3)];
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic op_t pick_op(phase_t mode);
		int r;
		r = $urandom_range(0, 99);
		case (mode)
			PH_FILL: return (r < 65) ? OP_PUSH : OP_PUSH_UNIQUE;
			PH_DRAIN: begin
				if (r < 60) return OP_POP;
				if (r < 70) return OP_TOP;
				if (r < 82) return OP_TOP_OF_TYPE;
				if (r < 92) return OP_CONTAINS;
				if (r < 96) return OP_PUSH;
				return OP_NONE;
			end
			default: begin
				if (r < 25) return OP_PUSH;
				if (r < 40) return OP_PUSH_UNIQUE;
				if (r < 55) return OP_POP;
				if (r < 65) return OP_TOP;
				if (r < 78) return OP_TOP_OF_TYPE;
				if (r < 93) return OP_CONTAINS;
				if (r < 95) return OP_CLEAR;
				return OP_NONE;
			end
		endcase
	endfunction

	// receiver: checks each beat, stalls on a mode that changes every so often
	initial begin : receiver
		int  hold_left;
		int  mode_left;
		int  mode;
		bit  hold_done;
		hold_left = 0;
		mode_left = 0;
		mode = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				check_beat(m_tdata);
			// one long hold-off so the parked result backs up the input side
			if (!hold_done && cmds_accepted >= $size(directed_rows) + 60) begin
				hold_left = LONG_HOLD;
				hold_done = 1'b1;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(32, 128);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (mode == 0) begin
				m_tready <= 1'b1;
			end else if (mode == 1) begin
				m_tready <= 1'($urandom_range(0, 1));
			end else begin
				m_tready <= ($urandom_range(0, 3) == 0);
			end
		end
	end

	initial begin : stimulus
		cmd_t   c;
		phase_t mode;
		int     phase;
		int     len;
		int     rand_sent;
		bit     drained;
		phase = 0;
		rand_sent = 0;
		drained = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed_rows[k]) begin
			c.op    = directed_rows[k].op;
			c.value = directed_rows[k].value;
			c.tag   = directed_rows[k].tag;
			send_cmd(c, directed_rows[k].known, directed_rows[k].res);
		end

		foreach (value_pool[i])
			value_pool[i] = {$urandom, $urandom};
		foreach (tag_pool[i])
			tag_pool[i] = 8'($urandom_range(0, 255));

		// first phase fills past DEPTH so full pushes show up early
		while (rand_sent < RANDOM_ITEMS) begin
			mode = (phase == 0) ? PH_FILL : phase_t'($urandom_range(0, 2));
			len = (phase == 0) ? DEPTH + 16 : $urandom_range(10, DEPTH + 16);
			for (int n = 0; n < len && rand_sent < RANDOM_ITEMS; n++) begin
				if (!drained && rand_sent == RANDOM_ITEMS / 2) begin
					s_tvalid <= 1'b0;
					do @(posedge clk); while (results_due.size() != 0);
					drained = 1'b1;
				end
				c.op    = pick_op(mode);
				c.value = pick_value();
				c.tag   = pick_tag();
				send_cmd(c, 1'b0, '0);
				rand_sent++;
			end
			phase++;
		end
		s_tvalid <= 1'b0;

		while (results_due.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
